// ===== hdl/ppdlsu_pkg.sv =====
// Shared types, opcode tables and constants of the peripheral-processor load/store unit.
package ppdlsu_pkg;

   // Values of the request's action field.
   localparam logic [1:0] ACT_EXEC = 2'd0;
   localparam logic [1:0] ACT_HWR  = 2'd1;
   localparam logic [1:0] ACT_HRD  = 2'd2;
   localparam logic [1:0] ACT_NOP  = 2'd3;

   // Instruction classes in decode order.
   localparam logic [4:0] CLS_LD   = 5'd0;
   localparam logic [4:0] CLS_ST   = 5'd1;
   localparam logic [4:0] CLS_AD   = 5'd2;
   localparam logic [4:0] CLS_SB   = 5'd3;
   localparam logic [4:0] CLS_SHN  = 5'd4;
   localparam logic [4:0] CLS_LM   = 5'd5;
   localparam logic [4:0] CLS_LP   = 5'd6;
   localparam logic [4:0] CLS_SCN  = 5'd7;
   localparam logic [4:0] CLS_RA   = 5'd8;
   localparam logic [4:0] CLS_AO   = 5'd9;
   localparam logic [4:0] CLS_SO   = 5'd10;
   localparam logic [4:0] CLS_JM   = 5'd11;
   localparam logic [4:0] CLS_JN   = 5'd12;
   localparam logic [4:0] CLS_RD   = 5'd13;
   localparam logic [4:0] CLS_CR   = 5'd14;
   localparam logic [4:0] CLS_RDL  = 5'd15;
   localparam logic [4:0] CLS_CW   = 5'd16;
   localparam logic [4:0] CLS_CTRL = 5'd17;
   localparam logic [4:0] CLS_IOJ  = 5'd18;
   localparam logic [4:0] CLS_IN   = 5'd19;
   localparam logic [4:0] CLS_OUT  = 5'd20;
   localparam logic [4:0] CLS_PSN  = 5'd21;
   localparam logic [4:0] CLS_KPT  = 5'd22;
   localparam logic [4:0] CLS_EXN  = 5'd23;
   localparam logic [4:0] CLS_MXN  = 5'd24;
   localparam logic [4:0] CLS_MAN  = 5'd25;
   localparam logic [4:0] CLS_MAN2 = 5'd26;
   localparam logic [4:0] CLS_INPN = 5'd27;
   localparam logic [4:0] CLS_UNK  = 5'd28;
   // Table markers that need a second look at the s bit or the d field.
   localparam logic [4:0] CLS_SIO  = 5'd30;
   localparam logic [4:0] CLS_SXJ  = 5'd31;

   // Function codes with special load behaviour.
   localparam logic [5:0] F_LDN = 6'o14;
   localparam logic [5:0] F_LCN = 6'o15;
   localparam logic [5:0] F_LDC = 6'o20;

   // Addressing mode, taken from the upper octal digit of f.
   localparam logic [2:0] MODE_DIRECT   = 3'd3;
   localparam logic [2:0] MODE_INDIRECT = 3'd4;
   localparam logic [2:0] MODE_MEMORY   = 3'd5;

   // Exchange subcodes in the d field.
   localparam logic [5:0] D_MXN     = 6'o10;
   localparam logic [5:0] D_MAN     = 6'o20;
   localparam logic [5:0] D_MAN2_LO = 6'o30;
   localparam logic [5:0] D_MAN2_HI = 6'o37;
   localparam logic [5:0] D_EXN_LIM = 6'o10;

   localparam logic [5:0] LCN_HIGH = 6'h3F;

   localparam logic [4:0] SHORT_SET [64] = '{
      CLS_PSN, CLS_JM,  CLS_JM,  CLS_JN,  CLS_JN,  CLS_JN,  CLS_JN,  CLS_JN,
      CLS_SHN, CLS_LM,  CLS_LP,  CLS_SCN, CLS_LD,  CLS_LD,  CLS_AD,  CLS_SB,
      CLS_LD,  CLS_AD,  CLS_LP,  CLS_LM,  CLS_RD,  CLS_RD,  CLS_SXJ, CLS_KPT,
      CLS_LD,  CLS_AD,  CLS_SB,  CLS_LM,  CLS_ST,  CLS_RA,  CLS_AO,  CLS_SO,
      CLS_LD,  CLS_AD,  CLS_SB,  CLS_LM,  CLS_ST,  CLS_RA,  CLS_AO,  CLS_SO,
      CLS_LD,  CLS_AD,  CLS_SB,  CLS_LM,  CLS_ST,  CLS_RA,  CLS_AO,  CLS_SO,
      CLS_CR,  CLS_CR,  CLS_CW,  CLS_CW,  CLS_SIO, CLS_SIO, CLS_SIO, CLS_SIO,
      CLS_IN,  CLS_IN,  CLS_OUT, CLS_OUT, CLS_CTRL, CLS_CTRL, CLS_CTRL, CLS_CTRL
   };

   localparam logic [4:0] LONG_SET [64] = '{
      CLS_RDL, CLS_RDL, CLS_PSN, CLS_PSN, CLS_PSN, CLS_PSN, CLS_PSN, CLS_PSN,
      CLS_PSN, CLS_PSN, CLS_PSN, CLS_PSN, CLS_PSN, CLS_PSN, CLS_PSN, CLS_PSN,
      CLS_PSN, CLS_PSN, CLS_LP,  CLS_LP,  CLS_LP,  CLS_PSN, CLS_INPN, CLS_PSN,
      CLS_LD,  CLS_AD,  CLS_SB,  CLS_LM,  CLS_ST,  CLS_RA,  CLS_AO,  CLS_SO,
      CLS_LD,  CLS_AD,  CLS_SB,  CLS_LM,  CLS_ST,  CLS_RA,  CLS_AO,  CLS_SO,
      CLS_LD,  CLS_AD,  CLS_SB,  CLS_LM,  CLS_ST,  CLS_RA,  CLS_AO,  CLS_SO,
      CLS_CR,  CLS_CR,  CLS_CW,  CLS_CW,  CLS_SIO, CLS_SIO, CLS_PSN, CLS_PSN,
      CLS_PSN, CLS_IN,  CLS_PSN, CLS_OUT, CLS_PSN, CLS_UNK, CLS_PSN, CLS_PSN
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_SUB,
      ST_ACCESS,
      ST_LATCH,
      ST_DONE
   } state_type;

   // Which memory access of the instruction is in progress.
   typedef enum logic [1:0] {
      STEP_M,
      STEP_D,
      STEP_W,
      STEP_WR
   } step_type;

   typedef struct packed {
      logic     capture;
      step_type step;
      logic     mul;
      logic     sub;
      logic     rd;
      logic     wr;
      logic     latch;
      logic     finish;
   } cmd_type;

   typedef struct packed {
      logic need_m;
      logic need_d;
      logic need_w;
      logic need_wr;
   } plan_type;

   function automatic logic [4:0] decode_class(input logic [5:0] f, input logic g,
                                               input logic [5:0] d, input logic s);
      logic [4:0] c;
      logic [4:0] r;
      c = g ? LONG_SET[f] : SHORT_SET[f];
      r = c;
      if (c == CLS_SIO) begin
         r = s ? CLS_CTRL : CLS_IOJ;
      end else if (c == CLS_SXJ) begin
         if (d < D_EXN_LIM) begin
            r = CLS_EXN;
         end else if (d == D_MXN) begin
            r = CLS_MXN;
         end else if (d == D_MAN) begin
            r = CLS_MAN;
         end else if (d inside {[D_MAN2_LO:D_MAN2_HI]}) begin
            r = CLS_MAN2;
         end else begin
            r = CLS_UNK;
         end
      end
      return r;
   endfunction

endpackage

// ===== hdl/ppdlsu_if.sv =====
// Request and response channel interfaces of the load/store unit.
interface ppdlsu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [5:0]  function_code;
   logic        extended;
   logic [5:0]  d_field;
   logic        select_bit;
   logic [15:0] program_address;
   logic [15:0] host_address;
   logic [15:0] host_data;

   modport source (
      output valid, action, function_code, extended, d_field, select_bit,
             program_address, host_address, host_data,
      input  ready
   );
   modport sink (
      input  valid, action, function_code, extended, d_field, select_bit,
             program_address, host_address, host_data,
      output ready
   );
endinterface

interface ppdlsu_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  instruction_class;
   logic [1:0]  length_words;
   logic [17:0] accumulator;
   logic [15:0] read_data;

   modport source (
      output valid, instruction_class, length_words, accumulator, read_data,
      input  ready
   );
   modport sink (
      input  valid, instruction_class, length_words, accumulator, read_data,
      output ready
   );
endinterface

// ===== hdl/ppdlsu_ctrl.sv =====
// Sequencer that steps each request through its memory accesses.
module ppdlsu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  ppdlsu_pkg::plan_type plan,
   output ppdlsu_pkg::cmd_type  cmd
);
   import ppdlsu_pkg::*;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic      go_after_d, go_after_m, go_first;
   step_type  step_after_d, step_after_m, step_first;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_M;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The accesses always run in the order m word, d word, operand word or store.
   always_comb begin
      go_after_d   = plan.need_w | plan.need_wr;
      step_after_d = plan.need_w ? STEP_W : STEP_WR;
      go_after_m   = plan.need_d | go_after_d;
      step_after_m = plan.need_d ? STEP_D : step_after_d;
      go_first     = plan.need_m | go_after_m;
      step_first   = plan.need_m ? STEP_M : step_after_m;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      cmd.step     = step_ff;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            step_in  = step_first;
            state_in = go_first ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            if (step_ff == STEP_WR) begin
               cmd.wr   = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = ST_LATCH;
            end
         end
         ST_LATCH: begin
            cmd.latch = 1'b1;
            case (step_ff)
               STEP_M: begin
                  step_in  = step_after_m;
                  state_in = go_after_m ? ST_MUL : ST_DONE;
               end
               STEP_D: begin
                  step_in  = step_after_d;
                  state_in = go_after_d ? ST_MUL : ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            // The result register is free, or its transfer completes now.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/ppdlsu_dp.sv =====
// Datapath: request registers, decoder, address reduction, word memory and accumulator.
module ppdlsu_dp #(
   parameter int MEMORY_WORDS = 16384
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ppdlsu_pkg::cmd_type  cmd,
   output ppdlsu_pkg::plan_type plan,
   input  logic [1:0]           req_action,
   input  logic [5:0]           req_function_code,
   input  logic                 req_extended,
   input  logic [5:0]           req_d_field,
   input  logic                 req_select_bit,
   input  logic [15:0]          req_program_address,
   input  logic [15:0]          req_host_address,
   input  logic [15:0]          req_host_data,
   output logic [4:0]           rsp_instruction_class,
   output logic [1:0]           rsp_length_words,
   output logic [17:0]          rsp_accumulator,
   output logic [15:0]          rsp_read_data
);
   import ppdlsu_pkg::*;

   localparam int AW       = $clog2(MEMORY_WORDS);
   localparam int RECIP_W  = 33 - AW;
   localparam int PROD_W   = 16 + RECIP_W;
   localparam int QW       = PROD_W - 32;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / MEMORY_WORDS);
   localparam logic [16:0] MW = 17'(MEMORY_WORDS);

   logic [15:0] mem [MEMORY_WORDS];

   logic [1:0]  act_ff;
   logic [5:0]  f_ff;
   logic        g_ff;
   logic [5:0]  d_ff;
   logic        s_ff;
   logic [15:0] p_ff;
   logic [15:0] ha_ff;
   logic [15:0] hd_ff;
   logic [15:0] m_ff;
   logic [15:0] dw_ff;
   logic [15:0] rd_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [16:0] rem_ff, rem_in;
   logic [17:0] acc_ff, acc_in;
   logic [4:0]  cls_ff;
   logic [1:0]  len_ff;
   logic [15:0] rdata_ff;

   logic [4:0]  cls;
   logic        exec, is_ld, is_st, ld_imm, ldc, ld_mem, m_mode, i_mode;
   logic [2:0]  mode;
   logic [15:0] opnd_addr, src_addr, wdata;
   logic [16:0] rem_fix;
   logic [AW-1:0] maddr;
   logic [1:0]  len;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         f_ff   <= req_function_code;
         g_ff   <= req_extended;
         d_ff   <= req_d_field;
         s_ff   <= req_select_bit;
         p_ff   <= req_program_address;
         ha_ff  <= req_host_address;
         hd_ff  <= req_host_data;
      end
      if (cmd.latch && cmd.step == STEP_M) begin
         m_ff <= rd_ff;
      end
      if (cmd.latch && cmd.step == STEP_D) begin
         dw_ff <= rd_ff;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(src_addr) * PROD_W'(RECIP);
      end
      if (cmd.sub) begin
         rem_ff <= rem_in;
      end
      if (cmd.finish) begin
         cls_ff   <= exec ? cls : CLS_LD;
         len_ff   <= len;
         rdata_ff <= (act_ff == ACT_HRD) ? rd_ff : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 18'd0;
      end else if (cmd.finish) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[maddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_ff <= mem[maddr];
      end
   end

   always_comb begin
      cls    = decode_class(f_ff, g_ff, d_ff, s_ff);
      exec   = (act_ff == ACT_EXEC);
      is_ld  = exec && (cls == CLS_LD);
      is_st  = exec && (cls == CLS_ST);
      ld_imm = is_ld && ((f_ff == F_LDN) || (f_ff == F_LCN));
      ldc    = is_ld && (f_ff == F_LDC);
      ld_mem = is_ld && !ld_imm && !ldc;
      mode   = f_ff[5:3];
      m_mode = (mode == MODE_MEMORY);
      i_mode = (mode == MODE_INDIRECT);

      plan.need_m  = ldc || ((ld_mem || is_st) && m_mode);
      plan.need_d  = (ld_mem || is_st) && (i_mode || (m_mode && (d_ff != 6'd0)));
      plan.need_w  = ld_mem || (act_ff == ACT_HRD);
      plan.need_wr = is_st || (act_ff == ACT_HWR);

      if (is_ld || is_st) begin
         len = (m_mode || ldc) ? 2'd2 : 2'd1;
      end else begin
         len = 2'd0;
      end
   end

   // Operand address of the direct, indirect and memory modes.
   always_comb begin
      if (mode == MODE_INDIRECT) begin
         opnd_addr = dw_ff;
      end else if (mode == MODE_MEMORY) begin
         opnd_addr = (d_ff == 6'd0) ? m_ff : 16'(m_ff + dw_ff);
      end else begin
         opnd_addr = {10'd0, d_ff};
      end
   end

   always_comb begin
      case (cmd.step)
         STEP_M:  src_addr = 16'(p_ff + 16'd1);
         STEP_D:  src_addr = {10'd0, d_ff};
         default: src_addr = exec ? opnd_addr : ha_ff;
      endcase
   end

   // Address modulo the memory size: a reciprocal estimate of the quotient that
   // is at most one low, then one compare and subtract at the access.
   always_comb begin
      rem_in  = 17'({1'b0, src_addr} - 17'(17'(prod_ff[PROD_W-1 -: QW]) * MW));
      rem_fix = (rem_ff >= MW) ? 17'(rem_ff - MW) : rem_ff;
      maddr   = rem_fix[AW-1:0];
   end

   always_comb begin
      if (act_ff == ACT_HWR) begin
         wdata = hd_ff;
      end else begin
         wdata = g_ff ? acc_ff[15:0] : {4'd0, acc_ff[11:0]};
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (is_ld) begin
         if (f_ff == F_LDN) begin
            acc_in = {12'd0, d_ff};
         end else if (f_ff == F_LCN) begin
            acc_in = {12'hFFF, LCN_HIGH ^ d_ff};
         end else if (ldc) begin
            acc_in = {d_ff, m_ff[11:0]};
         end else begin
            acc_in = g_ff ? {2'd0, rd_ff} : {6'd0, rd_ff[11:0]};
         end
      end
   end

   assign rsp_instruction_class = cls_ff;
   assign rsp_length_words      = len_ff;
   assign rsp_accumulator       = acc_ff;
   assign rsp_read_data         = rdata_ff;

endmodule

// ===== hdl/pp_decode_load_store_unit_top.sv =====
// Top level of the peripheral-processor decode and load/store unit.
//
// Each request transfer on req_if carries one action: execute an instruction,
// write a memory word for the host, read one back, or do nothing. Exactly one
// response transfer on rsp_if follows each request, in order, with the decoded
// class, the instruction length, the accumulator after the step and any read
// word. One request is handled at a time: it is taken, decoded, each memory
// access runs in turn, and the result register is loaded. Each access reduces
// the address modulo MEMORY_WORDS on the shared multiplier, a multiply and then
// a subtract, then uses the single memory port; a read then latches the word.
// Operand-only forms make no access, a host write or read makes one, and
// memory-mode loads read the m word, the d word when d is nonzero, and the
// operand in turn. The result sits in an output register, so the next
// request is taken while a response still waits; a stalled receiver holds
// the block only once the next result is ready to be loaded.
// Synchronous reset clears the accumulator and the controller. The word memory
// is not cleared; words must be written by the host before they are read.
module pp_decode_load_store_unit_top #(
   parameter int MEMORY_WORDS = 16384
) (
   input logic          clock,
   input logic          reset,
   ppdlsu_req_if.sink   req_if,
   ppdlsu_rsp_if.source rsp_if
);
   import ppdlsu_pkg::*;

   cmd_type  cmd;
   plan_type plan;

   ppdlsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .plan      (plan),
      .cmd       (cmd)
   );

   ppdlsu_dp #(
      .MEMORY_WORDS (MEMORY_WORDS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .plan                  (plan),
      .req_action            (req_if.action),
      .req_function_code     (req_if.function_code),
      .req_extended          (req_if.extended),
      .req_d_field           (req_if.d_field),
      .req_select_bit        (req_if.select_bit),
      .req_program_address   (req_if.program_address),
      .req_host_address      (req_if.host_address),
      .req_host_data         (req_if.host_data),
      .rsp_instruction_class (rsp_if.instruction_class),
      .rsp_length_words      (rsp_if.length_words),
      .rsp_accumulator       (rsp_if.accumulator),
      .rsp_read_data         (rsp_if.read_data)
   );

endmodule
